FILE: rtl/gnpa_pkg.sv
// Package for the greedy nearest-pair assigner.
// Holds sizes, command and status codes, payload structs and sequencer states.
// No dependencies.
package gnpa_pkg;

   localparam int MAX_REQUESTERS = 32;
   localparam int MAX_RESOURCES  = 64;
   localparam int COORD_BITS     = 10;

   localparam int REQ_IDX_BITS = $clog2(MAX_REQUESTERS);
   localparam int REQ_CNT_BITS = $clog2(MAX_REQUESTERS + 1);
   localparam int RES_IDX_BITS = $clog2(MAX_RESOURCES);
   localparam int RES_CNT_BITS = $clog2(MAX_RESOURCES + 1);
   localparam int CNT_BITS     = (REQ_CNT_BITS > RES_CNT_BITS) ? REQ_CNT_BITS : RES_CNT_BITS;
   localparam int DIST_BITS    = COORD_BITS + 1;

   localparam int RSP_REQ_BITS = 5;
   localparam int RSP_RES_BITS = 6;

   localparam logic [1:0] CMD_LOAD_REQ = 2'd0;
   localparam logic [1:0] CMD_LOAD_RES = 2'd1;
   localparam logic [1:0] CMD_SOLVE    = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [COORD_BITS-1:0] x_coord;
      logic [COORD_BITS-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [RSP_REQ_BITS-1:0] requester_index;
      logic [RSP_RES_BITS-1:0] resource_index;
      logic                    status;
      logic                    last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_EMIT,
      ST_ERROR
   } state_type;

endpackage

FILE: rtl/gnpa_dist.sv
// Shared Manhattan distance unit with registered output.
// Depends on gnpa_pkg.
module gnpa_dist (
   input  logic                        clock,
   input  gnpa_pkg::point_type         pa,
   input  gnpa_pkg::point_type         pb,
   output logic [gnpa_pkg::DIST_BITS-1:0] distance
);
   import gnpa_pkg::*;

   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic [DIST_BITS-1:0]  dist_in;
   logic [DIST_BITS-1:0]  dist_ff;

   always_comb begin
      dx      = (pa.x > pb.x) ? (pa.x - pb.x) : (pb.x - pa.x);
      dy      = (pa.y > pb.y) ? (pa.y - pb.y) : (pb.y - pa.y);
      dist_in = DIST_BITS'(dx) + DIST_BITS'(dy);
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign distance = dist_ff;

endmodule

FILE: rtl/greedy_nearest_pair_assigner_top.sv
// Greedy nearest-pair assigner, top level.
// Depends on gnpa_pkg and gnpa_dist.
//
// Load commands (requester or resource point) keep busy low, so loads can
// be issued back to back. A solve raises busy and runs R rounds, R being
// the requester count and S the resource count; each round walks every
// requester/resource pair through the single distance unit, one pair per
// cycle, then drains the pair pipeline and commits the chosen pair.
// The R results then leave back to back, rsp_strobe high for one cycle
// each; the last strobe comes in the first cycle with busy low. A rejected
// solve (overflow, no requesters or too few resources) gives a single error
// result, from the error state through the result register.
// There is no backpressure on the result side: the receiver must take every
// strobe.
module greedy_nearest_pair_assigner_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gnpa_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output gnpa_pkg::rsp_type rsp_payload
);
   import gnpa_pkg::*;

   state_type state_ff, state_in;

   logic [REQ_CNT_BITS-1:0] req_cnt_ff;
   logic [RES_CNT_BITS-1:0] res_cnt_ff;
   logic                    overflow_ff;

   point_type req_mem [MAX_REQUESTERS];
   point_type res_mem [MAX_RESOURCES];
   point_type req_rd_ff;
   point_type res_rd_ff;

   logic [MAX_REQUESTERS-1:0] assigned_vld_ff;
   logic [RES_IDX_BITS-1:0]   assigned_res_ff [MAX_REQUESTERS];
   logic [MAX_RESOURCES-1:0]  taken_ff;

   logic [REQ_IDX_BITS-1:0] i_ff;
   logic [RES_IDX_BITS-1:0] j_ff;
   logic [REQ_CNT_BITS-1:0] round_ff;
   logic [REQ_IDX_BITS-1:0] k_ff;

   logic                    s1_vld_ff, s1_live_ff, s1_last_ff;
   logic [REQ_IDX_BITS-1:0] s1_i_ff;
   logic [RES_IDX_BITS-1:0] s1_j_ff;
   logic                    s2_vld_ff, s2_live_ff, s2_last_ff;
   logic [REQ_IDX_BITS-1:0] s2_i_ff;
   logic [RES_IDX_BITS-1:0] s2_j_ff;
   logic [DIST_BITS-1:0]    pair_dist;

   logic                    best_vld_ff;
   logic [DIST_BITS-1:0]    best_d_ff;
   logic [REQ_IDX_BITS-1:0] best_i_ff;
   logic [RES_IDX_BITS-1:0] best_j_ff;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_strobe_ff, rsp_strobe_in;

   logic take;
   logic load_req, load_res, solve_go;
   logic solve_bad;
   logic j_end, i_end, last_issue;
   logic round_end, emit_last;
   logic issue, commit, run_clear;
   logic better;

   point_type ld_pt;

   assign take     = start && !busy;
   assign ld_pt.x  = req_payload.x_coord;
   assign ld_pt.y  = req_payload.y_coord;
   assign solve_bad = overflow_ff || (req_cnt_ff == '0) ||
                      (CNT_BITS'(req_cnt_ff) > CNT_BITS'(res_cnt_ff));

   assign j_end      = RES_CNT_BITS'(j_ff) == (res_cnt_ff - RES_CNT_BITS'(1));
   assign i_end      = REQ_CNT_BITS'(i_ff) == (req_cnt_ff - REQ_CNT_BITS'(1));
   assign last_issue = i_end && j_end;
   assign round_end  = (round_ff + REQ_CNT_BITS'(1)) == req_cnt_ff;
   assign emit_last  = REQ_CNT_BITS'(k_ff) == (req_cnt_ff - REQ_CNT_BITS'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && req_payload.cmd == CMD_SOLVE) begin
               state_in = solve_bad ? ST_ERROR : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_vld_ff && s2_last_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = round_end ? ST_EMIT : ST_SCAN;
         end
         ST_EMIT: begin
            if (emit_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy          = 1'b1;
      load_req      = 1'b0;
      load_res      = 1'b0;
      solve_go      = 1'b0;
      issue         = 1'b0;
      commit        = 1'b0;
      run_clear     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in.requester_index = RSP_REQ_BITS'(k_ff);
      rsp_in.resource_index  = RSP_RES_BITS'(assigned_res_ff[k_ff]);
      rsp_in.status          = STATUS_OK;
      rsp_in.last            = emit_last;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            load_req = start && req_payload.cmd == CMD_LOAD_REQ;
            load_res = start && req_payload.cmd == CMD_LOAD_RES;
            solve_go = start && req_payload.cmd == CMD_SOLVE;
         end
         ST_SCAN:   issue  = 1'b1;
         ST_DRAIN:  issue  = 1'b0;
         ST_COMMIT: commit = 1'b1;
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            run_clear     = emit_last;
         end
         ST_ERROR: begin
            rsp_strobe_in          = 1'b1;
            run_clear              = 1'b1;
            rsp_in.requester_index = '0;
            rsp_in.resource_index  = '0;
            rsp_in.status          = STATUS_ERR;
            rsp_in.last            = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // point stores
   always_ff @(posedge clock) begin
      if (load_req && req_cnt_ff < REQ_CNT_BITS'(MAX_REQUESTERS)) begin
         req_mem[req_cnt_ff[REQ_IDX_BITS-1:0]] <= ld_pt;
      end
      req_rd_ff <= req_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (load_res && res_cnt_ff < RES_CNT_BITS'(MAX_RESOURCES)) begin
         res_mem[res_cnt_ff[RES_IDX_BITS-1:0]] <= ld_pt;
      end
      res_rd_ff <= res_mem[j_ff];
   end

   // counts and overflow
   always_ff @(posedge clock) begin
      if (reset || run_clear) begin
         req_cnt_ff  <= '0;
         res_cnt_ff  <= '0;
         overflow_ff <= 1'b0;
      end else begin
         if (load_req) begin
            if (req_cnt_ff < REQ_CNT_BITS'(MAX_REQUESTERS)) begin
               req_cnt_ff <= req_cnt_ff + REQ_CNT_BITS'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (load_res) begin
            if (res_cnt_ff < RES_CNT_BITS'(MAX_RESOURCES)) begin
               res_cnt_ff <= res_cnt_ff + RES_CNT_BITS'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end
      end
   end

   // scan walk
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff     <= '0;
         j_ff     <= '0;
         round_ff <= '0;
         k_ff     <= '0;
      end else begin
         if (solve_go || commit) begin
            i_ff <= '0;
            j_ff <= '0;
         end else if (issue && !last_issue) begin
            if (j_end) begin
               j_ff <= '0;
               i_ff <= i_ff + REQ_IDX_BITS'(1);
            end else begin
               j_ff <= j_ff + RES_IDX_BITS'(1);
            end
         end
         if (solve_go) begin
            round_ff <= '0;
         end else if (commit) begin
            round_ff <= round_ff + REQ_CNT_BITS'(1);
         end
         if (solve_go) begin
            k_ff <= '0;
         end else if (state_ff == ST_EMIT) begin
            k_ff <= k_ff + REQ_IDX_BITS'(1);
         end
      end
   end

   // pair pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_live_ff <= !assigned_vld_ff[i_ff] && !taken_ff[j_ff];
      s1_last_ff <= last_issue;
      s1_i_ff    <= i_ff;
      s1_j_ff    <= j_ff;
      s2_live_ff <= s1_live_ff;
      s2_last_ff <= s1_last_ff;
      s2_i_ff    <= s1_i_ff;
      s2_j_ff    <= s1_j_ff;
   end

   gnpa_dist u_dist (
      .clock    (clock),
      .pa       (req_rd_ff),
      .pb       (res_rd_ff),
      .distance (pair_dist)
   );

   assign better = s2_vld_ff && s2_live_ff && (!best_vld_ff || pair_dist < best_d_ff);

   always_ff @(posedge clock) begin
      if (reset || solve_go || commit) begin
         best_vld_ff <= 1'b0;
      end else if (better) begin
         best_vld_ff <= 1'b1;
      end
      if (better) begin
         best_d_ff <= pair_dist;
         best_i_ff <= s2_i_ff;
         best_j_ff <= s2_j_ff;
      end
   end

   // assignment state
   always_ff @(posedge clock) begin
      if (reset || run_clear) begin
         assigned_vld_ff <= '0;
         taken_ff        <= '0;
      end else if (commit) begin
         assigned_vld_ff[best_i_ff] <= 1'b1;
         taken_ff[best_j_ff]        <= 1'b1;
      end
      if (commit) begin
         assigned_res_ff[best_i_ff] <= best_j_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_commit_has_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> best_vld_ff)
      else $error("commit without a chosen pair");

   a_emit_assigned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> assigned_vld_ff[k_ff])
      else $error("emitting an unassigned requester");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_EMIT || $past(state_ff) == ST_ERROR))
      else $error("result transfer outside emit");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> !taken_ff[best_j_ff] && !assigned_vld_ff[best_i_ff])
      else $error("commit reuses a resource or requester");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_cnt_ff <= REQ_CNT_BITS'(MAX_REQUESTERS) && res_cnt_ff <= RES_CNT_BITS'(MAX_RESOURCES))
      else $error("point count beyond capacity");

endmodule
